[rtl/fsmn_pkg.sv]
// shared types and constants for the font scale matrix normalizer
// used by fsmn_sdiv, fsmn_ctrl, font_scale_matrix_normalize and fsmn_check
`timescale 1ns / 1ps
`default_nettype none

package fsmn_pkg;

  // field widths
  localparam int IN_W       = 18;  // input matrix entry
  localparam int ENT_W      = 23;  // working matrix entry, holds any pixel value
  localparam int NUM_W      = 30;  // point value times resolution plus rounding
  localparam int DVD_W      = 34;  // divider dividend, covers entry shifted by EM_SHIFT
  localparam int QUO_W      = 23;  // divider quotient bits, one per cycle
  localparam int DVS_W      = 15;  // divider divisor
  localparam int EM_W       = 15;
  localparam int RES_W      = 11;
  localparam int EXP_W      = 5;
  localparam int DIAG_W     = 9;
  localparam int OUT_W      = 18;
  localparam int EM_SHIFT   = 11;
  localparam int CFG_IDX_W  = 2;

  localparam int S_TDATA_W  = 4 * IN_W;
  localparam int OUT_BITS   = 2 * DIAG_W + 5 * OUT_W + EXP_W;
  localparam int M_TDATA_W  = ((OUT_BITS + 7) / 8) * 8;

  localparam logic signed [ENT_W-1:0] DIAG_LIMIT   = 177;
  localparam logic signed [ENT_W-1:0] ZERO_PX      = 16;
  localparam logic signed [IN_W-1:0]  ZERO_PAIR_PT = 12;
  localparam logic signed [NUM_W-1:0] PT_ROUND     = 36;
  localparam logic [DVS_W-1:0]        PT_DIV       = 72;
  localparam logic [EM_W-1:0]         EM_UNIT      = 2048;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_EM_UNITS = 2'd0,
    REG_X_RES    = 2'd1,
    REG_Y_RES    = 2'd2
  } reg_idx_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_MUL,
    ST_LOAD_PT,
    ST_DIV_PT,
    ST_FIX,
    ST_SHIFT,
    ST_EM_DOWN,
    ST_EM_UP,
    ST_LOAD_EM,
    ST_DIV_EM,
    ST_DONE
  } state_t;

  // sequencer commands to the datapath
  typedef struct packed {
    logic ready;
    logic mul;
    logic load_pt;
    logic fix;
    logic shift;
    logic em_down;
    logic em_up;
    logic load_em;
    logic take_em;
    logic finish;
  } ctrl_t;

  // datapath status to the sequencer
  typedef struct packed {
    logic in_valid;
    logic pixels;
    logic div_busy;
    logic need_shift;
    logic em_above;
    logic em_below;
    logic ex_zero;
    logic out_free;
  } stat_t;

endpackage

`default_nettype wire

[rtl/fsmn_sdiv.sv]
// bit-serial signed divider lane, one quotient bit per cycle, truncates toward zero
// depends on fsmn_pkg for widths
`timescale 1ns / 1ps
`default_nettype none

module fsmn_sdiv (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                start,
  input  logic signed [fsmn_pkg::DVD_W-1:0]   dividend,
  input  logic        [fsmn_pkg::DVS_W-1:0]   divisor,
  output logic                                busy,
  output logic signed [fsmn_pkg::QUO_W-1:0]   quotient
);
  import fsmn_pkg::*;

  localparam int CNT_W = $clog2(QUO_W);

  logic               active;
  logic [CNT_W-1:0]   cnt;
  logic               neg;
  logic [DVS_W-1:0]   dvs;
  logic [DVS_W-1:0]   rem;
  logic [QUO_W-1:0]   quo;
  logic [DVD_W-1:0]   mag;
  logic [DVS_W:0]     sh;
  logic [DVS_W:0]     diff;
  logic               ge;

  assign mag  = dividend[DVD_W-1] ? -dividend : dividend;
  assign sh   = {rem, quo[QUO_W-1]};
  assign ge   = sh >= {1'b0, dvs};
  assign diff = sh - {1'b0, dvs};

  always_ff @(posedge clk) begin
    if (rst) begin
      active <= 1'b0;
      cnt    <= '0;
    end else if (start) begin
      active <= 1'b1;
      cnt    <= '0;
    end else if (active) begin
      cnt <= cnt + 1'b1;
      if (cnt == CNT_W'(QUO_W - 1)) begin
        active <= 1'b0;
      end
    end
  end

  // the bits above the quotient range are always below the divisor, so they seed the remainder
  always_ff @(posedge clk) begin
    if (start) begin
      neg <= dividend[DVD_W-1];
      dvs <= divisor;
      rem <= DVS_W'(mag[DVD_W-1:QUO_W]);
      quo <= mag[QUO_W-1:0];
    end else if (active) begin
      rem <= ge ? diff[DVS_W-1:0] : sh[DVS_W-1:0];
      quo <= {quo[QUO_W-2:0], ge};
    end
  end

  assign busy     = active;
  assign quotient = neg ? -$signed(quo) : $signed(quo);

endmodule

`default_nettype wire

[rtl/fsmn_ctrl.sv]
// sequencer: steps one item through point conversion, fix step, shift loop, em loop and rescale
// depends on fsmn_pkg for the state and command types
`timescale 1ns / 1ps
`default_nettype none

module fsmn_ctrl (
  input  logic            clk,
  input  logic            rst,
  input  fsmn_pkg::stat_t stat,
  output fsmn_pkg::ctrl_t ctl
);
  import fsmn_pkg::*;

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE:    if (stat.in_valid) state_next = ST_MUL;
      ST_MUL:     state_next = stat.pixels ? ST_FIX : ST_LOAD_PT;
      ST_LOAD_PT: state_next = ST_DIV_PT;
      ST_DIV_PT:  if (!stat.div_busy) state_next = ST_FIX;
      ST_FIX:     state_next = ST_SHIFT;
      ST_SHIFT:   if (!stat.need_shift) state_next = ST_EM_DOWN;
      ST_EM_DOWN: if (!stat.em_above || stat.ex_zero) state_next = ST_EM_UP;
      ST_EM_UP: begin
        if (!stat.em_below) begin
          state_next = stat.em_above ? ST_LOAD_EM : ST_DONE;
        end
      end
      ST_LOAD_EM: state_next = ST_DIV_EM;
      ST_DIV_EM:  if (!stat.div_busy) state_next = ST_DONE;
      ST_DONE:    if (stat.out_free) state_next = ST_IDLE;
      default:    state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    ctl = '0;
    unique case (state)
      ST_IDLE:    ctl.ready   = 1'b1;
      ST_MUL:     ctl.mul     = 1'b1;
      ST_LOAD_PT: ctl.load_pt = 1'b1;
      ST_DIV_PT:  ;
      ST_FIX:     ctl.fix     = 1'b1;
      ST_SHIFT:   ctl.shift   = stat.need_shift;
      ST_EM_DOWN: ctl.em_down = stat.em_above && !stat.ex_zero;
      ST_EM_UP:   ctl.em_up   = stat.em_below;
      ST_LOAD_EM: ctl.load_em = 1'b1;
      ST_DIV_EM:  ctl.take_em = !stat.div_busy;
      ST_DONE:    ctl.finish  = stat.out_free;
      default:    ;
    endcase
  end

endmodule

`default_nettype wire

[rtl/font_scale_matrix_normalize.sv]
// top level of the font scale matrix normalizer: registers, datapath, output word
// depends on fsmn_pkg, fsmn_sdiv and fsmn_ctrl
`timescale 1ns / 1ps
`default_nettype none

// Takes one 2x2 size matrix at a time, in points or pixels, and returns the normalized
// scale matrix, its exponent and the ppem values. An item in pixels goes through the fix
// step, s one-bit shift steps that bring xx and yy within +-177 and e em halving or
// doubling steps, and its output word is written once the output register is free; an
// item in points first goes through the conversion by 72, and an em size that does not
// settle at 2048 adds a rescale through the dividers. Processing time is set by the four
// bit-serial divider lanes (a load step, then a wait while they are busy) and the
// one-step-per-cycle shift and em loops. One item is processed at a time; a new item is
// taken while the previous output word still waits. The user must write configuration
// registers through the cfg port only while the block is idle; the block itself does not
// enforce this.
module font_scale_matrix_normalize #(
  parameter int DEFAULT_RES = 96
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 s_axis_tvalid,
  output logic                                 s_axis_tready,
  // size_xx, size_xy, size_yx, size_yy
  input  logic [fsmn_pkg::S_TDATA_W-1:0]       s_axis_tdata,
  // req_type
  input  logic                                 s_axis_tuser,
  output logic                                 m_axis_tvalid,
  input  logic                                 m_axis_tready,
  // scale_xx, scale_xy, scale_yx, scale_yy, scale_exponent, ppem_x, ppem_y, ppem_mean,
  // zero padding
  output logic [fsmn_pkg::M_TDATA_W-1:0]       m_axis_tdata,
  input  logic                                 cfg_we,
  input  logic [fsmn_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [fsmn_pkg::EM_W-1:0]            cfg_wdata
);
  import fsmn_pkg::*;

  localparam int LANES = 4;
  localparam logic signed [ENT_W:0] SAT_HI = (ENT_W+1)'(2 ** (OUT_W - 1) - 1);
  localparam logic signed [ENT_W:0] SAT_LO = -(ENT_W+1)'(2 ** (OUT_W - 1));

  function automatic logic signed [OUT_W-1:0] sat_out(input logic signed [ENT_W:0] v);
    logic signed [OUT_W-1:0] r;
    if (v > SAT_HI) begin
      r = SAT_HI[OUT_W-1:0];
    end else if (v < SAT_LO) begin
      r = SAT_LO[OUT_W-1:0];
    end else begin
      r = v[OUT_W-1:0];
    end
    return r;
  endfunction

  ctrl_t ctl;
  stat_t stat;

  logic [EM_W-1:0]  em_units;
  logic [RES_W-1:0] x_resolution;
  logic [RES_W-1:0] y_resolution;

  logic signed [ENT_W-1:0] ent [LANES];
  logic signed [NUM_W-1:0] num [LANES];
  logic signed [ENT_W-1:0] px;
  logic signed [ENT_W-1:0] py;
  logic [EXP_W-1:0]        ex;
  logic [EM_W-1:0]         emv;
  logic                    pix;

  logic                    accept;
  logic                    zero_pair;
  logic                    res_dflt;
  logic [RES_W-1:0]        rx;
  logic [RES_W-1:0]        ry;
  logic signed [IN_W-1:0]  opnd [LANES];
  logic signed [NUM_W-1:0] num_next [LANES];
  logic signed [DVD_W-1:0] dvd_in [LANES];
  logic signed [QUO_W-1:0] quo [LANES];
  logic signed [ENT_W-1:0] src [LANES];
  logic signed [ENT_W-1:0] fixed [LANES];
  logic [LANES-1:0]        busy;
  logic                    div_start;
  logic [DVS_W-1:0]        div_dvs;
  logic signed [ENT_W:0]   ppem_sum;
  logic signed [ENT_W:0]   ppem_half;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      em_units     <= EM_UNIT;
      x_resolution <= '0;
      y_resolution <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_EM_UNITS: em_units     <= cfg_wdata;
        REG_X_RES:    x_resolution <= cfg_wdata[RES_W-1:0];
        REG_Y_RES:    y_resolution <= cfg_wdata[RES_W-1:0];
        default:      ;
      endcase
    end
  end

  assign s_axis_tready = ctl.ready;
  assign accept        = s_axis_tvalid && s_axis_tready;

  // point conversion operands
  assign zero_pair = (ent[0] == '0 && ent[1] == '0) || (ent[2] == '0 && ent[3] == '0);
  assign res_dflt  = (x_resolution == '0) || (y_resolution == '0);
  assign rx        = res_dflt ? RES_W'(DEFAULT_RES) : x_resolution;
  assign ry        = res_dflt ? RES_W'(DEFAULT_RES) : y_resolution;

  assign div_start = ctl.load_pt || ctl.load_em;
  assign div_dvs   = ctl.load_pt ? PT_DIV : DVS_W'(emv);

  for (genvar i = 0; i < LANES; i++) begin : g_lane
    assign opnd[i] = (zero_pair && (i == 0 || i == LANES - 1)) ? ZERO_PAIR_PT
                                                              : ent[i][IN_W-1:0];
    assign num_next[i] = opnd[i] * $signed({1'b0, (i < 2) ? rx : ry}) + PT_ROUND;
    assign dvd_in[i]   = ctl.load_pt ? DVD_W'(num[i])
                                     : (DVD_W'(ent[i]) <<< EM_SHIFT);
    assign src[i]      = pix ? ent[i] : quo[i];
    // diagonal entries of zero fall back to 16 pixels
    assign fixed[i]    = ((i == 0 || i == LANES - 1) && src[i] == '0) ? ZERO_PX : src[i];

    fsmn_sdiv u_sdiv (
      .clk      (clk),
      .rst      (rst),
      .start    (div_start),
      .dividend (dvd_in[i]),
      .divisor  (div_dvs),
      .busy     (busy[i]),
      .quotient (quo[i])
    );
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      for (int i = 0; i < LANES; i++) begin
        ent[i] <= ENT_W'($signed(s_axis_tdata[i*IN_W +: IN_W]));
      end
      pix <= s_axis_tuser;
    end else if (ctl.fix) begin
      for (int i = 0; i < LANES; i++) begin
        ent[i] <= fixed[i];
      end
    end else if (ctl.shift) begin
      for (int i = 0; i < LANES; i++) begin
        ent[i] <= ent[i] >>> 1;
      end
    end else if (ctl.take_em) begin
      for (int i = 0; i < LANES; i++) begin
        ent[i] <= quo[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.mul) begin
      for (int i = 0; i < LANES; i++) begin
        num[i] <= num_next[i];
      end
    end
    if (ctl.fix) begin
      px <= fixed[0];
      py <= fixed[LANES-1];
    end
  end

  // exponent and em tracking
  always_ff @(posedge clk) begin
    if (accept) begin
      ex  <= '0;
      emv <= (em_units == '0) ? EM_UNIT : em_units;
    end else if (ctl.shift || ctl.em_up) begin
      ex <= ex + 1'b1;
      if (ctl.em_up) begin
        emv <= emv << 1;
      end
    end else if (ctl.em_down) begin
      ex  <= ex - 1'b1;
      emv <= emv >> 1;
    end
  end

  assign stat.in_valid   = s_axis_tvalid;
  assign stat.pixels     = pix;
  assign stat.div_busy   = |busy;
  assign stat.need_shift = (ent[0] > DIAG_LIMIT) || (ent[0] < -DIAG_LIMIT) ||
                           (ent[LANES-1] > DIAG_LIMIT) || (ent[LANES-1] < -DIAG_LIMIT);
  assign stat.em_above   = emv > EM_UNIT;
  assign stat.em_below   = emv < EM_UNIT;
  assign stat.ex_zero    = ex == '0;
  assign stat.out_free   = !m_axis_tvalid || m_axis_tready;

  fsmn_ctrl u_ctrl (
    .clk  (clk),
    .rst  (rst),
    .stat (stat),
    .ctl  (ctl)
  );

  // output word
  assign ppem_sum  = (ENT_W+1)'(px) + (ENT_W+1)'(py);
  assign ppem_half = ppem_sum >>> 1;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (ctl.finish) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.finish) begin
      m_axis_tdata <= {{(M_TDATA_W - OUT_BITS){1'b0}},
                       sat_out(ppem_half),
                       sat_out((ENT_W+1)'(py)),
                       sat_out((ENT_W+1)'(px)),
                       ex,
                       ent[LANES-1][DIAG_W-1:0],
                       sat_out((ENT_W+1)'(ent[2])),
                       sat_out((ENT_W+1)'(ent[1])),
                       ent[0][DIAG_W-1:0]};
    end
  end

endmodule

`default_nettype wire

[rtl/fsmn_check.sv]
// port-level checker for the font scale matrix normalizer, bound to the top level
// depends on fsmn_pkg for the output word width
`timescale 1ns / 1ps
`default_nettype none

module fsmn_check (
  input logic                             clk,
  input logic                             rst,
  input logic                             s_axis_tvalid,
  input logic                             s_axis_tready,
  input logic                             m_axis_tvalid,
  input logic                             m_axis_tready,
  input logic [fsmn_pkg::M_TDATA_W-1:0]   m_axis_tdata
);
  import fsmn_pkg::*;

  logic       s_take;
  logic       m_take;
  logic [1:0] pending;

  assign s_take = s_axis_tvalid && s_axis_tready;
  assign m_take = m_axis_tvalid && m_axis_tready;

  // items taken in whose word has not yet left
  always_ff @(posedge clk) begin
    if (rst) begin
      pending <= '0;
    end else begin
      pending <= pending + {1'b0, s_take} - {1'b0, m_take};
    end
  end

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("output word changed while stalled");

  a_reset_quiet: assert property (@(posedge clk) rst |=> !m_axis_tvalid)
    else $error("output valid after reset");

  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    s_take |=> !s_axis_tready)
    else $error("input taken while an item is in progress");

  a_word_has_item: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> pending != 2'd0 && pending != 2'd3)
    else $error("output word without a matching input or too many items held");

  a_diag_range: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> $signed(m_axis_tdata[DIAG_W-1:0]) <= 177 &&
                      $signed(m_axis_tdata[DIAG_W-1:0]) >= -177)
    else $error("scale_xx outside the normalized range");

endmodule

bind font_scale_matrix_normalize fsmn_check u_fsmn_check (
  .clk           (clk),
  .rst           (rst),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);

`default_nettype wire
